// ===== rtl/core/point_segment_distance_defines.svh =====
// Assertion macros shared by the point to segment distance checker.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef POINT_SEGMENT_DISTANCE_DEFINES_SVH
`define POINT_SEGMENT_DISTANCE_DEFINES_SVH

// same-cycle implication, off while reset is asserted
`define PSD_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off while reset is asserted
`define PSD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/psd_pkg.sv =====
// Shared types and constants for the point to segment distance pipeline.
// No dependencies.
`default_nettype none

package psd_pkg;

    // projection parameter: Q1.16, 1.0 = 2^16
    localparam int T_BITS = 16;
    // result field width
    localparam int DIST_W = 25;

    typedef logic [T_BITS:0]   tpar_t;
    typedef logic [DIST_W-1:0] dist_t;

    localparam tpar_t T_ONE  = tpar_t'(1) << T_BITS;
    localparam dist_t DIST_MAX = '1;

    // how t is formed for an item
    typedef enum logic [1:0] {
        TM_DIV  = 2'b00,   // quotient of the divider
        TM_ZERO = 2'b01,   // point behind start or zero-length segment
        TM_FULL = 2'b10    // point beyond end
    } tmode_t;

endpackage

`default_nettype wire

// ===== rtl/core/psd_prep.sv =====
// Front stages: coordinate differences, products, squared length and dot product.
// Depends on psd_pkg.
`default_nettype none

module psd_prep
    import psd_pkg::*;
#(
    parameter int COORD_BITS = 16,
    localparam int D_W = COORD_BITS + 1,
    localparam int P_W = 2 * D_W,
    localparam int A_W = 2 * COORD_BITS + 2,
    localparam int N_W = 2 * COORD_BITS + 3
)
(
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   en,
    input  wire                   vld_i,
    input  wire  [COORD_BITS-1:0] px,
    input  wire  [COORD_BITS-1:0] py,
    input  wire  [COORD_BITS-1:0] sx,
    input  wire  [COORD_BITS-1:0] sy,
    input  wire  [COORD_BITS-1:0] ex,
    input  wire  [COORD_BITS-1:0] ey,
    output logic                  vld_o,
    output logic signed [D_W-1:0] dx_o,
    output logic signed [D_W-1:0] dy_o,
    output logic signed [D_W-1:0] wx_o,
    output logic signed [D_W-1:0] wy_o,
    output logic [A_W-1:0]        a_o,
    output logic signed [N_W-1:0] num_o
);

    logic                  v1_reg, v2_reg, v3_reg;
    logic signed [D_W-1:0] dx1_reg, dy1_reg, wx1_reg, wy1_reg;
    logic signed [D_W-1:0] dx2_reg, dy2_reg, wx2_reg, wy2_reg;
    logic signed [D_W-1:0] dx3_reg, dy3_reg, wx3_reg, wy3_reg;
    logic signed [P_W-1:0] sqx_reg, sqy_reg, crx_reg, cry_reg;
    logic [A_W-1:0]        a_reg;
    logic signed [N_W-1:0] num_reg;

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= vld_i;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // stage 1: segment direction and point offset from start
    // stage 2: products; stage 3: sums
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dx1_reg <= $signed({ex[COORD_BITS-1], ex}) - $signed({sx[COORD_BITS-1], sx});
            dy1_reg <= $signed({ey[COORD_BITS-1], ey}) - $signed({sy[COORD_BITS-1], sy});
            wx1_reg <= $signed({px[COORD_BITS-1], px}) - $signed({sx[COORD_BITS-1], sx});
            wy1_reg <= $signed({py[COORD_BITS-1], py}) - $signed({sy[COORD_BITS-1], sy});

            sqx_reg <= dx1_reg * dx1_reg;
            sqy_reg <= dy1_reg * dy1_reg;
            crx_reg <= dx1_reg * wx1_reg;
            cry_reg <= dy1_reg * wy1_reg;
            dx2_reg <= dx1_reg;
            dy2_reg <= dy1_reg;
            wx2_reg <= wx1_reg;
            wy2_reg <= wy1_reg;

            a_reg   <= $unsigned(sqx_reg) + $unsigned(sqy_reg);
            num_reg <= $signed({crx_reg[P_W-1], crx_reg}) + $signed({cry_reg[P_W-1], cry_reg});
            dx3_reg <= dx2_reg;
            dy3_reg <= dy2_reg;
            wx3_reg <= wx2_reg;
            wy3_reg <= wy2_reg;
        end
    end

    assign vld_o = v3_reg;
    assign dx_o  = dx3_reg;
    assign dy_o  = dy3_reg;
    assign wx_o  = wx3_reg;
    assign wy_o  = wy3_reg;
    assign a_o   = a_reg;
    assign num_o = num_reg;

endmodule

`default_nettype wire

// ===== rtl/core/psd_div.sv =====
// Pipelined restoring divider for t = num / a, one quotient bit per stage, with clamping.
// Depends on psd_pkg.
`default_nettype none

module psd_div
    import psd_pkg::*;
#(
    parameter int COORD_BITS = 16,
    localparam int D_W = COORD_BITS + 1,
    localparam int A_W = 2 * COORD_BITS + 2,
    localparam int N_W = 2 * COORD_BITS + 3
)
(
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   en,
    input  wire                   vld_i,
    input  wire  signed [D_W-1:0] dx_i,
    input  wire  signed [D_W-1:0] dy_i,
    input  wire  signed [D_W-1:0] wx_i,
    input  wire  signed [D_W-1:0] wy_i,
    input  wire  [A_W-1:0]        a_i,
    input  wire  signed [N_W-1:0] num_i,
    output logic                  vld_o,
    output logic signed [D_W-1:0] dx_o,
    output logic signed [D_W-1:0] dy_o,
    output logic signed [D_W-1:0] wx_o,
    output logic signed [D_W-1:0] wy_o,
    output tpar_t                 t_o,
    output logic                  degen_o
);

    localparam int SIDE_W = 4 * D_W;

    logic [A_W-1:0]    rem_reg   [0:T_BITS];
    logic [A_W-1:0]    den_reg   [0:T_BITS];
    logic [T_BITS-1:0] q_reg     [0:T_BITS];
    tmode_t            mode_reg  [0:T_BITS];
    logic [SIDE_W-1:0] side_reg  [0:T_BITS];
    logic              degen_reg [0:T_BITS];
    logic              vld_reg   [0:T_BITS];

    tmode_t mode_next;
    logic   num_pos;

    // entry: classify the item
    always_comb
    begin
        num_pos = !num_i[N_W-1] && (num_i != '0);
        if (a_i == '0 || !num_pos)
            mode_next = TM_ZERO;
        else if (num_i[A_W-1:0] >= a_i)
            mode_next = TM_FULL;
        else
            mode_next = TM_DIV;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg[0] <= 1'b0;
        else if (en)
            vld_reg[0] <= vld_i;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0]   <= (mode_next == TM_DIV) ? num_i[A_W-1:0] : '0;
            den_reg[0]   <= a_i;
            q_reg[0]     <= '0;
            mode_reg[0]  <= mode_next;
            side_reg[0]  <= {dx_i, dy_i, wx_i, wy_i};
            degen_reg[0] <= (a_i == '0);
        end
    end

    // one quotient bit per stage
    for (genvar i = 1; i <= T_BITS; i++)
    begin : g_stage
        logic [A_W:0] sh;
        logic         ge;

        always_comb
        begin
            sh = {rem_reg[i-1], 1'b0};
            ge = (sh >= {1'b0, den_reg[i-1]});
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[i] <= 1'b0;
            else if (en)
                vld_reg[i] <= vld_reg[i-1];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[i]   <= ge ? A_W'(sh - {1'b0, den_reg[i-1]}) : sh[A_W-1:0];
                q_reg[i]     <= {q_reg[i-1][T_BITS-2:0], ge};
                den_reg[i]   <= den_reg[i-1];
                mode_reg[i]  <= mode_reg[i-1];
                side_reg[i]  <= side_reg[i-1];
                degen_reg[i] <= degen_reg[i-1];
            end
        end
    end

    // clamp
    always_comb
    begin
        case (mode_reg[T_BITS])
            TM_DIV:  t_o = {1'b0, q_reg[T_BITS]};
            TM_FULL: t_o = T_ONE;
            TM_ZERO: t_o = '0;
            default: t_o = '0;
        endcase
    end

    assign vld_o   = vld_reg[T_BITS];
    assign degen_o = degen_reg[T_BITS];
    assign dx_o    = side_reg[T_BITS][4*D_W-1 -: D_W];
    assign dy_o    = side_reg[T_BITS][3*D_W-1 -: D_W];
    assign wx_o    = side_reg[T_BITS][2*D_W-1 -: D_W];
    assign wy_o    = side_reg[T_BITS][D_W-1 -: D_W];

endmodule

`default_nettype wire

// ===== rtl/core/psd_proj.sv =====
// Offset from the projected point and its squared length, split into narrow products.
// Depends on psd_pkg.
`default_nettype none

module psd_proj
    import psd_pkg::*;
#(
    parameter int COORD_BITS = 16,
    parameter int FRAC_BITS  = 8,
    localparam int D_W   = COORD_BITS + 1,
    localparam int O_W   = D_W + T_BITS + 2,
    localparam int S_W   = 2 * O_W + 1,
    localparam int SHIFT = 2 * (T_BITS - FRAC_BITS),
    localparam int RAD_W = S_W - SHIFT
)
(
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   en,
    input  wire                   vld_i,
    input  wire  signed [D_W-1:0] dx_i,
    input  wire  signed [D_W-1:0] dy_i,
    input  wire  signed [D_W-1:0] wx_i,
    input  wire  signed [D_W-1:0] wy_i,
    input  tpar_t                 t_i,
    input  wire                   degen_i,
    output logic                  vld_o,
    output logic [RAD_W-1:0]      rad_o,
    output logic                  degen_o
);

    localparam int L = (O_W + 1) / 2;
    localparam int H = O_W - L;

    logic [4:0]             vld_reg;
    logic [4:0]             degen_reg;
    logic signed [O_W-1:0]  pdx_reg, pdy_reg;
    logic signed [D_W-1:0]  wxa_reg, wya_reg;
    logic signed [O_W-1:0]  offx, offy;
    logic [O_W-1:0]         magx_reg, magy_reg;
    logic [2*H-1:0]         hhx_reg, hhy_reg;
    logic [H+L-1:0]         hlx_reg, hly_reg;
    logic [2*L-1:0]         llx_reg, lly_reg;
    logic [2*H:0]           shh_reg;
    logic [H+L:0]           shl_reg;
    logic [2*L:0]           sll_reg;
    logic [S_W-1:0]         sum;
    logic [RAD_W-1:0]       rad_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[3:0], vld_i};
    end

    // offset = (P - S) * 2^16 - d * t
    always_comb
    begin
        offx = ($signed({{(O_W-D_W){wxa_reg[D_W-1]}}, wxa_reg}) <<< T_BITS) - pdx_reg;
        offy = ($signed({{(O_W-D_W){wya_reg[D_W-1]}}, wya_reg}) <<< T_BITS) - pdy_reg;
    end

    // squared length = hh << 2L + hl << (L+1) + ll
    always_comb
    begin
        sum = (S_W'(shh_reg) << (2 * L)) + (S_W'(shl_reg) << (L + 1)) + S_W'(sll_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // A: d * t
            pdx_reg <= dx_i * $signed({1'b0, t_i});
            pdy_reg <= dy_i * $signed({1'b0, t_i});
            wxa_reg <= wx_i;
            wya_reg <= wy_i;

            // B: magnitude of the offset
            magx_reg <= offx[O_W-1] ? $unsigned(-offx) : $unsigned(offx);
            magy_reg <= offy[O_W-1] ? $unsigned(-offy) : $unsigned(offy);

            // C: partial squares
            hhx_reg <= magx_reg[O_W-1:L] * magx_reg[O_W-1:L];
            hlx_reg <= magx_reg[O_W-1:L] * magx_reg[L-1:0];
            llx_reg <= magx_reg[L-1:0] * magx_reg[L-1:0];
            hhy_reg <= magy_reg[O_W-1:L] * magy_reg[O_W-1:L];
            hly_reg <= magy_reg[O_W-1:L] * magy_reg[L-1:0];
            lly_reg <= magy_reg[L-1:0] * magy_reg[L-1:0];

            // D: add the two axes
            shh_reg <= {1'b0, hhx_reg} + {1'b0, hhy_reg};
            shl_reg <= {1'b0, hlx_reg} + {1'b0, hly_reg};
            sll_reg <= {1'b0, llx_reg} + {1'b0, lly_reg};

            // E: combine and drop unneeded fraction bits
            rad_reg <= sum[S_W-1:SHIFT];

            degen_reg <= {degen_reg[3:0], degen_i};
        end
    end

    assign vld_o   = vld_reg[4];
    assign degen_o = degen_reg[4];
    assign rad_o   = rad_reg;

endmodule

`default_nettype wire

// ===== rtl/core/psd_sqrt.sv =====
// Pipelined integer square root, one root bit per stage, saturated to the result width.
// Depends on psd_pkg.
`default_nettype none

module psd_sqrt
    import psd_pkg::*;
#(
    parameter int RAD_W = 47,
    localparam int R     = (RAD_W + 1) / 2,
    localparam int PAD_W = 2 * R,
    localparam int Z_W   = (R > DIST_W) ? R : DIST_W
)
(
    input  wire              clk,
    input  wire              rst_n,
    input  wire              en,
    input  wire              vld_i,
    input  wire  [RAD_W-1:0] rad_i,
    input  wire              degen_i,
    output logic             vld_o,
    output dist_t            dist_o,
    output logic             degen_o
);

    logic [R-1:0]     root_reg  [1:R];
    logic [R-1:0]     rem_reg   [1:R-1];
    logic [PAD_W-1:0] rad_reg   [1:R-1];
    logic             vld_reg   [1:R];
    logic             degen_reg [1:R];

    logic [R-1:0]     root_w  [0:R-1];
    logic [R-1:0]     rem_w   [0:R-1];
    logic [PAD_W-1:0] rad_w   [0:R-1];
    logic             vld_w   [0:R-1];
    logic             degen_w [0:R-1];

    logic [Z_W-1:0]   root_z;

    for (genvar i = 0; i < R; i++)
    begin : g_stage
        logic [R+1:0] rem_sh;
        logic [R+1:0] trial;
        logic         ge;

        if (i == 0)
        begin : g_src_in
            assign root_w[0]  = '0;
            assign rem_w[0]   = '0;
            assign rad_w[0]   = PAD_W'(rad_i);
            assign vld_w[0]   = vld_i;
            assign degen_w[0] = degen_i;
        end
        else
        begin : g_src_reg
            assign root_w[i]  = root_reg[i];
            assign rem_w[i]   = rem_reg[i];
            assign rad_w[i]   = rad_reg[i];
            assign vld_w[i]   = vld_reg[i];
            assign degen_w[i] = degen_reg[i];
        end

        // bring down two radicand bits, try root*4+1
        always_comb
        begin
            rem_sh = {rem_w[i], rad_w[i][PAD_W-1 -: 2]};
            trial  = {root_w[i], 2'b01};
            ge     = (rem_sh >= trial);
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[i+1] <= 1'b0;
            else if (en)
                vld_reg[i+1] <= vld_w[i];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                root_reg[i+1]  <= {root_w[i][R-2:0], ge};
                degen_reg[i+1] <= degen_w[i];
            end
        end

        if (i < R - 1)
        begin : g_carry
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[i+1] <= ge ? R'(rem_sh - trial) : rem_sh[R-1:0];
                    rad_reg[i+1] <= rad_w[i] << 2;
                end
            end
        end
    end

    // saturate
    always_comb
    begin
        root_z = Z_W'(root_reg[R]);
        if (root_z > Z_W'(DIST_MAX))
            dist_o = DIST_MAX;
        else
            dist_o = root_z[DIST_W-1:0];
    end

    assign vld_o   = vld_reg[R];
    assign degen_o = degen_reg[R];

endmodule

`default_nettype wire

// ===== rtl/core/point_segment_distance.sv =====
// Top level of the point to segment distance pipeline.
// Depends on psd_pkg, psd_prep, psd_div, psd_proj, psd_sqrt.
//
//  channel   signals                                      direction
//  input     in_valid, in_stall, point_x/y, start_x/y,    in (in_stall out)
//            end_x/y
//  output    out_valid, out_stall, distance_q8,           out (out_stall in)
//            degenerate
//
// One item enters per cycle while in_stall is low. The pipeline has 3 front
// stages, 17 divider stages, 5 offset/square stages, one stage per root bit
// of the square root, and the output register.
// Reset clears all valid bits; no clearing pass. While a result waits under
// out_stall the whole pipeline holds and in_stall is raised.
`default_nettype none

module point_segment_distance
    import psd_pkg::*;
#(
    parameter int COORD_BITS = 16,
    parameter int FRAC_BITS  = 8
)
(
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   in_valid,
    output logic                  in_stall,
    input  wire  [COORD_BITS-1:0] point_x,
    input  wire  [COORD_BITS-1:0] point_y,
    input  wire  [COORD_BITS-1:0] start_x,
    input  wire  [COORD_BITS-1:0] start_y,
    input  wire  [COORD_BITS-1:0] end_x,
    input  wire  [COORD_BITS-1:0] end_y,
    output logic                  out_valid,
    input  wire                   out_stall,
    output logic [DIST_W-1:0]     distance_q8,
    output logic                  degenerate
);

    localparam int D_W   = COORD_BITS + 1;
    localparam int A_W   = 2 * COORD_BITS + 2;
    localparam int N_W   = 2 * COORD_BITS + 3;
    localparam int O_W   = D_W + T_BITS + 2;
    localparam int RAD_W = 2 * O_W + 1 - 2 * (T_BITS - FRAC_BITS);

    logic                  en;

    logic                  pr_vld;
    logic signed [D_W-1:0] pr_dx, pr_dy, pr_wx, pr_wy;
    logic [A_W-1:0]        pr_a;
    logic signed [N_W-1:0] pr_num;

    logic                  dv_vld;
    logic signed [D_W-1:0] dv_dx, dv_dy, dv_wx, dv_wy;
    tpar_t                 dv_t;
    logic                  dv_degen;

    logic                  pj_vld;
    logic [RAD_W-1:0]      pj_rad;
    logic                  pj_degen;

    logic                  sq_vld;
    dist_t                 sq_dist;
    logic                  sq_degen;

    logic                  out_valid_reg;
    dist_t                 dist_reg;
    logic                  degen_reg;

    // the whole pipeline moves unless a result is held at the output
    assign en       = !(out_valid_reg && out_stall);
    assign in_stall = !en;

    psd_prep #(.COORD_BITS(COORD_BITS)) u_prep (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (en),
        .vld_i (in_valid),
        .px    (point_x),
        .py    (point_y),
        .sx    (start_x),
        .sy    (start_y),
        .ex    (end_x),
        .ey    (end_y),
        .vld_o (pr_vld),
        .dx_o  (pr_dx),
        .dy_o  (pr_dy),
        .wx_o  (pr_wx),
        .wy_o  (pr_wy),
        .a_o   (pr_a),
        .num_o (pr_num)
    );

    psd_div #(.COORD_BITS(COORD_BITS)) u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .vld_i   (pr_vld),
        .dx_i    (pr_dx),
        .dy_i    (pr_dy),
        .wx_i    (pr_wx),
        .wy_i    (pr_wy),
        .a_i     (pr_a),
        .num_i   (pr_num),
        .vld_o   (dv_vld),
        .dx_o    (dv_dx),
        .dy_o    (dv_dy),
        .wx_o    (dv_wx),
        .wy_o    (dv_wy),
        .t_o     (dv_t),
        .degen_o (dv_degen)
    );

    psd_proj #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_proj (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .vld_i   (dv_vld),
        .dx_i    (dv_dx),
        .dy_i    (dv_dy),
        .wx_i    (dv_wx),
        .wy_i    (dv_wy),
        .t_i     (dv_t),
        .degen_i (dv_degen),
        .vld_o   (pj_vld),
        .rad_o   (pj_rad),
        .degen_o (pj_degen)
    );

    psd_sqrt #(.RAD_W(RAD_W)) u_sqrt (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .vld_i   (pj_vld),
        .rad_i   (pj_rad),
        .degen_i (pj_degen),
        .vld_o   (sq_vld),
        .dist_o  (sq_dist),
        .degen_o (sq_degen)
    );

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= sq_vld;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dist_reg  <= sq_dist;
            degen_reg <= sq_degen;
        end
    end

    assign out_valid   = out_valid_reg;
    assign distance_q8 = dist_reg;
    assign degenerate  = degen_reg;

endmodule

`default_nettype wire

// ===== rtl/core/psd_check.sv =====
// Port-level checks for point_segment_distance, bound to the top level.
// Depends on psd_pkg and point_segment_distance_defines.svh.
`default_nettype none
`include "point_segment_distance_defines.svh"

module psd_check
    import psd_pkg::*;
(
    input wire              clk,
    input wire              rst_n,
    input wire              in_stall,
    input wire              out_valid,
    input wire              out_stall,
    input wire [DIST_W-1:0] distance_q8,
    input wire              degenerate
);

    // a held result keeps its value
    `PSD_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(distance_q8) && $stable(degenerate), "result changed while stalled")

    // input is only held back by a blocked output
    `PSD_ASSERT_NOW(a_in_stall_cause, in_stall, out_valid && out_stall, "input stalled without a blocked result")

    // a blocked output must stop the input, or items would be lost
    `PSD_ASSERT_NOW(a_in_stall_when_blocked, out_valid && out_stall, in_stall, "input open while result blocked")

endmodule

bind point_segment_distance psd_check u_psd_check (.*);

`default_nettype wire
